/* rtl/core/msyx_pkg.sv */
`timescale 1ns / 1ps

package msyx_pkg;

   localparam int PatchSize = 256;
   localparam int CountWidth = $clog2(PatchSize + 3);
   localparam int AddrWidth = 8;

   localparam logic [7:0] RealtimeFirst = 8'hF8;
   localparam logic [7:0] SysexStart = 8'hF0;
   localparam logic [7:0] SysexEnd = 8'hF7;
   localparam logic [7:0] HeaderZero = 8'h00;
   localparam logic [7:0] HeaderNonCommercial = 8'h7E;

   localparam logic [2:0] HeaderLastPos = 3'd4;

   localparam logic [6:0] CommandRead = 7'h01;
   localparam logic [6:0] CommandWrite = 7'h02;
   localparam logic [6:0] CommandPing = 7'h0F;

   localparam logic [1:0] CsrDeviceId = 2'd0;
   localparam logic [1:0] CsrChecksumEnabled = 2'd1;
   localparam logic [1:0] CsrMergerActive = 2'd2;

   typedef enum logic [2:0] {
      ReplyAck         = 3'd0,
      ReplyBadCommand  = 3'd1,
      ReplyTooFew      = 3'd2,
      ReplyTooMany     = 3'd3,
      ReplyBadChecksum = 3'd4,
      ReplyNoStorage   = 3'd5,
      ReplySendDump    = 3'd6
   } reply_code_type;

   typedef struct packed {
      logic [6:0] device_id;
      logic       checksum_enabled;
      logic       merger_active;
   } config_type;

   typedef struct packed {
      logic                  forwarding_enabled;
      logic                  write_valid;
      logic [AddrWidth-1:0]  write_address;
      logic [6:0]            write_data;
      logic                  reply_valid;
      logic [2:0]            reply_code;
      logic                  footer_first;
      logic [6:0]            reply_bank;
      logic [6:0]            reply_patch;
      logic                  store_commit;
   } result_type;

endpackage

/* rtl/core/msyx_req_if.sv */
`timescale 1ns / 1ps

interface msyx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;
   logic       storage_available;

   modport source (output valid, output midi_byte, output storage_available, input ready);
   modport sink (input valid, input midi_byte, input storage_available, output ready);
endinterface

/* rtl/core/msyx_rsp_if.sv */
`timescale 1ns / 1ps

interface msyx_rsp_if;
   logic       valid;
   logic       ready;
   logic       forwarding_enabled;
   logic       write_valid;
   logic [7:0] write_address;
   logic [6:0] write_data;
   logic       reply_valid;
   logic [2:0] reply_code;
   logic       footer_first;
   logic [6:0] reply_bank;
   logic [6:0] reply_patch;
   logic       store_commit;

   modport source (
      output valid, output forwarding_enabled, output write_valid, output write_address,
      output write_data, output reply_valid, output reply_code, output footer_first,
      output reply_bank, output reply_patch, output store_commit, input ready
   );
   modport sink (
      input valid, input forwarding_enabled, input write_valid, input write_address,
      input write_data, input reply_valid, input reply_code, input footer_first,
      input reply_bank, input reply_patch, input store_commit, output ready
   );
endinterface

/* rtl/core/msyx_parser.sv */
`timescale 1ns / 1ps

module msyx_parser
   import msyx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] midi_byte,
   input  logic       storage_available,
   input  config_type cfg,
   output result_type result
);

   logic [2:0]            header_count_ff, header_count_in;
   logic                  in_own_message_ff, in_own_message_in;
   logic                  command_seen_ff, command_seen_in;
   logic [6:0]            command_code_ff, command_code_in;
   logic                  bank_seen_ff, bank_seen_in;
   logic                  patch_seen_ff, patch_seen_in;
   logic [6:0]            bank_number_ff, bank_number_in;
   logic [6:0]            patch_number_ff, patch_number_in;
   logic [7:0]            running_sum_ff, running_sum_in;
   logic [6:0]            received_sum_ff, received_sum_in;
   logic [CountWidth-1:0] data_count_ff, data_count_in;

   logic [7:0]            expected_byte;
   logic                  header_match;
   logic [CountWidth-1:0] expected_count;
   logic                  checksum_good;
   reply_code_type        reply_code;

   always_comb begin
      case (header_count_ff)
         3'd0: expected_byte = SysexStart;
         3'd1: expected_byte = HeaderZero;
         3'd2: expected_byte = HeaderZero;
         3'd3: expected_byte = HeaderNonCommercial;
         default: expected_byte = {1'b0, cfg.device_id};
      endcase
      header_match = (header_count_ff <= HeaderLastPos) && (midi_byte == expected_byte);
   end

   assign expected_count = CountWidth'(PatchSize) + CountWidth'(cfg.checksum_enabled);
   assign checksum_good = !cfg.checksum_enabled || (received_sum_ff == ~running_sum_ff[6:0]);

   always_comb begin
      header_count_in = header_count_ff;
      in_own_message_in = in_own_message_ff;
      command_seen_in = command_seen_ff;
      command_code_in = command_code_ff;
      bank_seen_in = bank_seen_ff;
      patch_seen_in = patch_seen_ff;
      bank_number_in = bank_number_ff;
      patch_number_in = patch_number_ff;
      running_sum_in = running_sum_ff;
      received_sum_in = received_sum_ff;
      data_count_in = data_count_ff;
      reply_code = ReplyAck;
      result = '0;

      if (midi_byte >= RealtimeFirst) begin
      end else if (!in_own_message_ff) begin
         if (!header_match) begin
            header_count_in = '0;
            command_seen_in = 1'b0;
            command_code_in = '0;
            bank_seen_in = 1'b0;
            patch_seen_in = 1'b0;
         end else begin
            header_count_in = header_count_ff + 3'd1;
            if (header_count_ff == HeaderLastPos) begin
               in_own_message_in = 1'b1;
            end
         end
      end else if (midi_byte[7]) begin
         if (midi_byte == SysexEnd && command_seen_ff) begin
            result.reply_valid = 1'b1;
            if (command_code_ff == CommandRead) begin
               if (!patch_seen_ff) begin
                  reply_code = ReplyTooFew;
               end else if (!storage_available) begin
                  reply_code = ReplyNoStorage;
               end else begin
                  reply_code = ReplySendDump;
                  result.reply_bank = bank_number_ff;
                  result.reply_patch = patch_number_ff;
               end
            end else if (command_code_ff == CommandWrite) begin
               if (data_count_ff < expected_count) begin
                  reply_code = ReplyTooFew;
               end else if (data_count_ff > expected_count) begin
                  reply_code = ReplyTooMany;
               end else if (!checksum_good) begin
                  reply_code = ReplyBadChecksum;
               end else if (!storage_available) begin
                  reply_code = ReplyNoStorage;
               end else begin
                  result.store_commit = 1'b1;
                  result.reply_bank = bank_number_ff;
                  result.reply_patch = patch_number_ff;
               end
            end
         end
         header_count_in = '0;
         in_own_message_in = 1'b0;
         command_seen_in = 1'b0;
         command_code_in = '0;
         bank_seen_in = 1'b0;
         patch_seen_in = 1'b0;
      end else if (!command_seen_ff) begin
         command_seen_in = 1'b1;
         command_code_in = midi_byte[6:0];
         if (midi_byte[6:0] == CommandWrite) begin
            running_sum_in = '0;
            received_sum_in = '0;
            data_count_in = '0;
         end else if (midi_byte[6:0] != CommandRead && midi_byte[6:0] != CommandPing) begin
            result.reply_valid = 1'b1;
            reply_code = ReplyBadCommand;
            header_count_in = '0;
            in_own_message_in = 1'b0;
            command_seen_in = 1'b0;
            command_code_in = '0;
            bank_seen_in = 1'b0;
            patch_seen_in = 1'b0;
         end
      end else if (command_code_ff == CommandRead || command_code_ff == CommandWrite) begin
         if (!bank_seen_ff) begin
            bank_number_in = midi_byte[6:0];
            bank_seen_in = 1'b1;
         end else if (!patch_seen_ff) begin
            patch_number_in = midi_byte[6:0];
            patch_seen_in = 1'b1;
         end else if (command_code_ff == CommandWrite) begin
            if (data_count_ff < CountWidth'(PatchSize)) begin
               result.write_valid = 1'b1;
               result.write_address = data_count_ff[AddrWidth-1:0];
               result.write_data = midi_byte[6:0];
               running_sum_in = running_sum_ff + {1'b0, midi_byte[6:0]};
            end else if (data_count_ff == CountWidth'(PatchSize) && cfg.checksum_enabled) begin
               received_sum_in = midi_byte[6:0];
            end
            if (data_count_ff < CountWidth'(PatchSize + 2)) begin
               data_count_in = data_count_ff + CountWidth'(1);
            end
         end
      end

      result.reply_code = result.reply_valid ? reply_code : ReplyAck;
      result.footer_first = result.reply_valid && cfg.merger_active;
      result.forwarding_enabled = !in_own_message_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         in_own_message_ff <= 1'b0;
         command_seen_ff <= 1'b0;
         command_code_ff <= '0;
         bank_seen_ff <= 1'b0;
         patch_seen_ff <= 1'b0;
         bank_number_ff <= '0;
         patch_number_ff <= '0;
         running_sum_ff <= '0;
         received_sum_ff <= '0;
         data_count_ff <= '0;
      end else if (advance) begin
         header_count_ff <= header_count_in;
         in_own_message_ff <= in_own_message_in;
         command_seen_ff <= command_seen_in;
         command_code_ff <= command_code_in;
         bank_seen_ff <= bank_seen_in;
         patch_seen_ff <= patch_seen_in;
         bank_number_ff <= bank_number_in;
         patch_number_ff <= patch_number_in;
         running_sum_ff <= running_sum_in;
         received_sum_ff <= received_sum_in;
         data_count_ff <= data_count_in;
      end
   end

endmodule

/* rtl/core/midi_sysex_patch_command_parser_core.sv */
`timescale 1ns / 1ps
// Channel        Direction  Handshake      Contents
// req_channel    in         valid/ready    midi_byte, storage_available
// rsp_channel    out        valid/ready    one result item per input item
// csr_*          in         write enable   device_id, checksum_enabled, merger_active
//
// Each item is parsed in the cycle it is accepted and its result appears in the output
// register on the next cycle; one item per cycle is sustained while results are not stalled.
// The output register alone sets the rate: a new item is taken whenever it is empty or
// being emptied in the same cycle, so a stalled result stops the input only then.
// Reset clears the parser state, the output valid flag and restores the register defaults.

module midi_sysex_patch_command_parser_core
   import msyx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   msyx_req_if.sink    req_channel,
   msyx_rsp_if.source  rsp_channel,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_write_data
);

   config_type cfg_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic       accept;

   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign accept = req_channel.valid && req_channel.ready;

   msyx_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .advance           (accept),
      .midi_byte         (req_channel.midi_byte),
      .storage_available (req_channel.storage_available),
      .cfg               (cfg_ff),
      .result            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_id <= 7'h7F;
         cfg_ff.checksum_enabled <= 1'b1;
         cfg_ff.merger_active <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrDeviceId: cfg_ff.device_id <= csr_write_data;
            CsrChecksumEnabled: cfg_ff.checksum_enabled <= csr_write_data[0];
            CsrMergerActive: cfg_ff.merger_active <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.forwarding_enabled = rsp_ff.forwarding_enabled;
   assign rsp_channel.write_valid = rsp_ff.write_valid;
   assign rsp_channel.write_address = rsp_ff.write_address;
   assign rsp_channel.write_data = rsp_ff.write_data;
   assign rsp_channel.reply_valid = rsp_ff.reply_valid;
   assign rsp_channel.reply_code = rsp_ff.reply_code;
   assign rsp_channel.footer_first = rsp_ff.footer_first;
   assign rsp_channel.reply_bank = rsp_ff.reply_bank;
   assign rsp_channel.reply_patch = rsp_ff.reply_patch;
   assign rsp_channel.store_commit = rsp_ff.store_commit;

endmodule

/* bench/tb_midi_sysex_patch_command_parser_core.sv */
`timescale 1ns / 1ps

module tb_midi_sysex_patch_command_parser_core;
   import msyx_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int HoldOff = 200;
   localparam int PhaseItems = 15;

   localparam result_type Outside = '{forwarding_enabled: 1'b1, default: '0};
   localparam result_type Inside = '{default: '0};
   localparam result_type PingAck = '{forwarding_enabled: 1'b1, reply_valid: 1'b1,
                                      reply_code: ReplyAck, default: '0};
   localparam result_type BadCommand = '{forwarding_enabled: 1'b1, reply_valid: 1'b1,
                                         reply_code: ReplyBadCommand, default: '0};
   localparam result_type Dump = '{forwarding_enabled: 1'b1, reply_valid: 1'b1,
                                   reply_code: ReplySendDump, reply_bank: 7'h7F,
                                   reply_patch: 7'h00, default: '0};

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       storage;
      logic       given;
      result_type want;
   } directed_row_type;

   // Reset register values apply here, so the header ends in 7F.
   localparam directed_row_type DirectedRows [28] = '{
      '{8'hF8, 1'b0, 1'b1, Outside},
      '{8'hF0, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h7E, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b1, Inside},
      '{8'hFF, 1'b0, 1'b1, Inside},
      '{8'h0F, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'hF7, 1'b0, 1'b1, PingAck},
      '{8'hF0, 1'b1, 1'b0, '0},
      '{8'hF0, 1'b1, 1'b1, Outside},
      '{8'hF0, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h7E, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b1, BadCommand},
      '{8'hF0, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h7E, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'hF7, 1'b1, 1'b1, Dump}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [6:0] csr_write_data;
   logic row_given;
   result_type row_result;

   bit calm = 1'b0;
   bit hold_off_request = 1'b0;
   int stall_left = 0;
   int mismatches = 0;
   int fed_count = 0;
   int cycle_count = 0;
   result_type results_due [$];

   config_type cfg = '{device_id: 7'h7F, checksum_enabled: 1'b1, merger_active: 1'b0};
   logic [2:0] hdr_matched = '0;
   logic own_msg = 1'b0;
   logic cmd_taken = 1'b0;
   logic [6:0] cmd = '0;
   logic bank_taken = 1'b0;
   logic patch_taken = 1'b0;
   logic [6:0] bank_num = '0;
   logic [6:0] patch_num = '0;
   logic [7:0] data_sum = '0;
   logic [6:0] sum_byte = '0;
   logic [8:0] write_count = '0;

   msyx_req_if req_ch ();
   msyx_rsp_if rsp_ch ();

   midi_sysex_patch_command_parser_core dut (
      .clock(clock),
      .reset(reset),
      .req_channel(req_ch),
      .rsp_channel(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void drop_message();
      hdr_matched = '0;
      own_msg = 1'b0;
      cmd_taken = 1'b0;
      cmd = '0;
      bank_taken = 1'b0;
      patch_taken = 1'b0;
   endfunction

   function automatic result_type parse_midi_byte(input logic [7:0] b, input logic storage);
      result_type r;
      logic [8:0] hdr_want;
      logic [8:0] full_len;
      r = '0;
      if (b >= RealtimeFirst) begin
      end else if (!own_msg) begin
         case (hdr_matched)
            3'd0: hdr_want = {1'b0, SysexStart};
            3'd1, 3'd2: hdr_want = {1'b0, HeaderZero};
            3'd3: hdr_want = {1'b0, HeaderNonCommercial};
            HeaderLastPos: hdr_want = {2'b00, cfg.device_id};
            default: hdr_want = 9'h100;
         endcase
         if ({1'b0, b} != hdr_want) begin
            drop_message();
         end else begin
            hdr_matched = hdr_matched + 3'd1;
            if (hdr_matched == HeaderLastPos + 3'd1) own_msg = 1'b1;
         end
      end else if (b[7]) begin
         if (b == SysexEnd && cmd_taken) begin
            r.reply_valid = 1'b1;
            if (cmd == CommandRead) begin
               if (!patch_taken) begin
                  r.reply_code = ReplyTooFew;
               end else if (!storage) begin
                  r.reply_code = ReplyNoStorage;
               end else begin
                  r.reply_code = ReplySendDump;
                  r.reply_bank = bank_num;
                  r.reply_patch = patch_num;
               end
            end else if (cmd == CommandWrite) begin
               full_len = 9'(PatchSize) + 9'(cfg.checksum_enabled);
               if (write_count < full_len) begin
                  r.reply_code = ReplyTooFew;
               end else if (write_count > full_len) begin
                  r.reply_code = ReplyTooMany;
               end else if (cfg.checksum_enabled && sum_byte != ~data_sum[6:0]) begin
                  r.reply_code = ReplyBadChecksum;
               end else if (!storage) begin
                  r.reply_code = ReplyNoStorage;
               end else begin
                  r.reply_code = ReplyAck;
                  r.store_commit = 1'b1;
                  r.reply_bank = bank_num;
                  r.reply_patch = patch_num;
               end
            end else begin
               r.reply_code = ReplyAck;
            end
         end
         drop_message();
      end else if (!cmd_taken) begin
         cmd_taken = 1'b1;
         cmd = b[6:0];
         if (cmd == CommandWrite) begin
            data_sum = '0;
            sum_byte = '0;
            write_count = '0;
         end else if (cmd != CommandRead && cmd != CommandPing) begin
            r.reply_valid = 1'b1;
            r.reply_code = ReplyBadCommand;
            drop_message();
         end
      end else if (cmd == CommandRead || cmd == CommandWrite) begin
         if (!bank_taken) begin
            bank_num = b[6:0];
            bank_taken = 1'b1;
         end else if (!patch_taken) begin
            patch_num = b[6:0];
            patch_taken = 1'b1;
         end else if (cmd == CommandWrite) begin
            if (write_count < PatchSize) begin
               r.write_valid = 1'b1;
               r.write_address = write_count[7:0];
               r.write_data = b[6:0];
               data_sum = data_sum + b;
            end else if (write_count == PatchSize && cfg.checksum_enabled) begin
               sum_byte = b[6:0];
            end
            if (write_count < PatchSize + 2) write_count = write_count + 9'd1;
         end
      end
      r.forwarding_enabled = !own_msg;
      r.footer_first = r.reply_valid & cfg.merger_active;
      return r;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      result_type calc;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.forwarding_enabled = rsp_ch.forwarding_enabled;
            got.write_valid = rsp_ch.write_valid;
            got.write_address = rsp_ch.write_address;
            got.write_data = rsp_ch.write_data;
            got.reply_valid = rsp_ch.reply_valid;
            got.reply_code = rsp_ch.reply_code;
            got.footer_first = rsp_ch.footer_first;
            got.reply_bank = rsp_ch.reply_bank;
            got.reply_patch = rsp_ch.reply_patch;
            got.store_commit = rsp_ch.store_commit;
            if (results_due.size() == 0) begin
               $display("%0t: result item with none expected, expected nothing got %h",
                        $time, got);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               compare_field("forwarding_enabled", want.forwarding_enabled,
                             got.forwarding_enabled);
               compare_field("write_valid", want.write_valid, got.write_valid);
               compare_field("write_address", want.write_address, got.write_address);
               compare_field("write_data", want.write_data, got.write_data);
               compare_field("reply_valid", want.reply_valid, got.reply_valid);
               compare_field("reply_code", want.reply_code, got.reply_code);
               compare_field("footer_first", want.footer_first, got.footer_first);
               compare_field("reply_bank", want.reply_bank, got.reply_bank);
               compare_field("reply_patch", want.reply_patch, got.reply_patch);
               compare_field("store_commit", want.store_commit, got.store_commit);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            calc = parse_midi_byte(req_ch.midi_byte, req_ch.storage_available);
            results_due.push_back(row_given ? row_result : calc);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HoldOff;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic drive(input logic [7:0] b, input logic s, input logic given,
                        input result_type r);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.midi_byte <= b;
      req_ch.storage_available <= s;
      row_given <= given;
      row_result <= r;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic feed_byte(input logic [7:0] b, input logic s);
      if ($urandom_range(0, 19) == 0) begin
         drive(8'($urandom_range('hF8, 'hFF)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      if (b < RealtimeFirst) fed_count++;
      drive(b, s, 1'b0, '0);
   endtask

   task automatic send_header(input int upto);
      logic [7:0] h;
      for (int i = 0; i < upto; i++) begin
         case (i)
            0: h = SysexStart;
            3: h = HeaderNonCommercial;
            4: h = {1'b0, cfg.device_id};
            default: h = HeaderZero;
         endcase
         feed_byte(h, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic send_message(input logic [6:0] command, input int count, input bit good_sum,
                               input logic [7:0] last, input logic last_storage);
      logic [7:0] sum;
      logic [6:0] d;
      logic [6:0] check;
      sum = '0;
      send_header(5);
      feed_byte({1'b0, command}, 1'($urandom_range(0, 1)));
      for (int i = 0; i < count; i++) begin
         d = 7'($urandom_range(0, 127));
         if (command == CommandWrite && i >= 2) begin
            if (i - 2 < PatchSize) begin
               sum = sum + d;
            end else if (i - 2 == PatchSize && cfg.checksum_enabled) begin
               check = ~sum[6:0];
               d = good_sum ? check : check ^ 7'($urandom_range(1, 127));
            end
         end
         feed_byte({1'b0, d}, 1'($urandom_range(0, 1)));
      end
      feed_byte(last, last_storage);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [6:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      case (index)
         CsrDeviceId: cfg.device_id = value;
         CsrChecksumEnabled: cfg.checksum_enabled = value[0];
         CsrMergerActive: cfg.merger_active = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int kind;
      int start;
      int extra;
      logic [6:0] rnd_cmd;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.midi_byte = '0;
      req_ch.storage_available = 1'b0;
      row_given = 1'b0;
      row_result = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DirectedRows[i]) begin
         drive(DirectedRows[i].midi_byte, DirectedRows[i].storage, DirectedRows[i].given,
               DirectedRows[i].want);
      end

      for (int p = 0; p < 4; p++) begin
         req_ch.valid <= 1'b0;
         while (results_due.size() != 0) @(negedge clock);
         repeat (2) @(negedge clock);
         case (p)
            0: write_register(CsrDeviceId, 7'h00);
            1: write_register(CsrDeviceId, 7'h7F);
            default: write_register(CsrDeviceId, 7'($urandom_range(0, 127)));
         endcase
         write_register(CsrChecksumEnabled, {6'($urandom_range(0, 63)), p[0]});
         write_register(CsrMergerActive, {6'($urandom_range(0, 63)), 1'(p == 0 || p == 3)});
         if (p == 1) hold_off_request = 1'b1;
         if (p == 3) calm = 1'b1;

         // Each setting opens with a write; in the first two it is full length with a good sum, so commits are seen.
         if (p < 2) begin
            extra = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: extra = 0;
               1: extra = -1;
               2: extra = 1;
               default: extra = $urandom_range(2, 4);
            endcase
         end
         send_message(CommandWrite, 2 + PatchSize + cfg.checksum_enabled + extra,
                      p < 2 || $urandom_range(0, 1) == 1, SysexEnd, 1'b1);

         start = fed_count;
         while (fed_count - start < PhaseItems) begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
               send_message(CommandWrite,
                            2 + PatchSize + cfg.checksum_enabled + $urandom_range(0, 3) - 1,
                            $urandom_range(0, 3) != 0, SysexEnd, $urandom_range(0, 3) != 0);
            end else if (kind <= 2) begin
               send_message(CommandWrite, $urandom_range(0, 12), 1'b1, SysexEnd,
                            $urandom_range(0, 3) != 0);
            end else if (kind <= 6) begin
               send_message(CommandRead, $urandom_range(0, 4), 1'b1, SysexEnd,
                            $urandom_range(0, 3) != 0);
            end else if (kind <= 8) begin
               send_message(CommandPing, $urandom_range(0, 2), 1'b1, SysexEnd,
                            1'($urandom_range(0, 1)));
            end else if (kind == 9) begin
               do rnd_cmd = 7'($urandom_range(0, 127));
               while (rnd_cmd == CommandRead || rnd_cmd == CommandWrite ||
                      rnd_cmd == CommandPing);
               send_message(rnd_cmd, $urandom_range(0, 2), 1'b1, SysexEnd,
                            1'($urandom_range(0, 1)));
            end else if (kind <= 11) begin
               case ($urandom_range(0, 2))
                  0: rnd_cmd = CommandRead;
                  1: rnd_cmd = CommandWrite;
                  default: rnd_cmd = CommandPing;
               endcase
               send_message(rnd_cmd, $urandom_range(0, 4), 1'b1,
                            8'($urandom_range('h80, 'hF6)), 1'($urandom_range(0, 1)));
            end else if (kind == 12) begin
               send_header(5);
               feed_byte(8'($urandom_range('h80, 'hF7)), 1'($urandom_range(0, 1)));
            end else if (kind == 13) begin
               send_header($urandom_range(1, 4));
               feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
